@@ hw/rtl/fifo_queue_indexed_read_defines.svh @@
// Assertion macros for the checker file of the queue.
// Each macro expects clk and rst_n in scope and disables itself during reset.
`ifndef FIFO_QUEUE_INDEXED_READ_DEFINES_SVH
`define FIFO_QUEUE_INDEXED_READ_DEFINES_SVH

// Same-cycle implication.
`define FQIR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FQIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/fqir_pkg.sv @@
package fqir_pkg;

  // Queue geometry
  localparam int DEPTH     = 16;
  localparam int MAX_BYTES = 8;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Field widths
  localparam int DATA_W   = 64;
  localparam int TAG_W    = 8;
  localparam int INDEX_W  = 4;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int EB_W     = 4;

  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam int SUM_W = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;

  // Stream packing
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = CMD_W;
  localparam int OUT_TDATA_W = 200;
  localparam int OUT_TUSER_W = STATUS_W;

  // Register port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_ELEMENT_BYTES = 1'b0;   // word index, paddr[2]
  localparam logic [EB_W-1:0] EB_RESET = 4'd8;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 3'd0,
    STAT_SIZE  = 3'd1,
    STAT_EMPTY = 3'd2,
    STAT_RANGE = 3'd3,
    STAT_FULL  = 3'd4
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RESP = 1'b1
  } state_t;

  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    data_t wdata;
    logic  re;
    ptr_t  raddr;
  } mem_req_t;

  // Ring pointer advance; off stays below DEPTH wherever the result is used.
  function automatic ptr_t ptr_add(ptr_t p, logic [INDEX_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // Keep the low min(eb, MAX_BYTES) bytes, clear the rest.
  function automatic data_t size_mask(data_t d, logic [EB_W-1:0] eb);
    data_t m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      if ((i < int'(eb)) && (i < MAX_BYTES)) begin
        m[8*i +: 8] = 8'hFF;
      end
    end
    return d & m;
  endfunction

endpackage

@@ hw/rtl/fqir_store.sv @@
module fqir_store
  import fqir_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output data_t    rdata
);

  data_t mem [DEPTH];
  data_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/fifo_queue_indexed_read.sv @@
// FIFO queue with indexed read, 16 elements of up to 8 bytes in a ring store.
// Input words (in_*) carry one command each: push, pop, read at an index
// counted from the head, or clear. Every command yields exactly one result
// word (out_*) with a status, the element read, the front and back elements,
// the element count and an empty flag.
// The accept cycle updates the pointers and issues at most one slot-store
// access; the response stage then takes the registered read data into the
// output register. A new command is accepted only after the previous one
// has left the response stage.
// The output register holds a finished result while the receiver stalls;
// the next command is still taken and waits in the response stage until the
// output register frees up, so in_tready drops only for that stage.
// Reset (rst_n low, synchronous) empties the queue, zeroes both pointers and
// sets element_bytes to 8. The slot store itself is not cleared; only
// written slots are ever read. Write element_bytes over the APB port at
// address 0 only while no command is in flight.
module fifo_queue_indexed_read
  import fqir_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // tdata: push_data[63:0], elem_bytes[71:64], index[75:72], zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: cmd[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata: read_data[63:0], front_data[127:64], back_data[191:128],
  //        count[196:192], is_empty[197], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // tuser: status[2:0]
  output logic [OUT_TUSER_W-1:0] out_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  // Queue state
  state_t state_r, state_nxt;
  ptr_t   head_r, head_nxt;
  ptr_t   tail_r, tail_nxt;
  cnt_t   cnt_r, cnt_nxt;
  data_t  front_r, front_nxt;
  data_t  back_r, back_nxt;
  logic [EB_W-1:0] eb_r, eb_nxt;

  // Response stage: what the accept cycle decided
  status_t pend_status_r, pend_status_nxt;
  logic    pend_rd_r, pend_rd_nxt;     // read at index hit, take store data
  logic    pend_pop_r, pend_pop_nxt;   // pop left elements, refetch front

  // Output register
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  data_t   out_read_r, out_read_nxt;
  data_t   out_front_r, out_front_nxt;
  data_t   out_back_r, out_back_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;
  logic    out_empty_r, out_empty_nxt;

  mem_req_t mem_req;
  data_t    mem_rdata;

  // Input word fields
  cmd_t              in_cmd;
  data_t             in_push_data;
  logic [TAG_W-1:0]  in_elem_bytes;
  logic [INDEX_W-1:0] in_index;

  logic  in_fire;
  logic  out_load;
  logic  cfg_wr;
  data_t push_val;
  data_t front_val;

  assign in_cmd        = cmd_t'(in_tuser[CMD_W-1:0]);
  assign in_push_data  = in_tdata[DATA_W-1:0];
  assign in_elem_bytes = in_tdata[DATA_W +: TAG_W];
  assign in_index      = in_tdata[DATA_W+TAG_W +: INDEX_W];

  // One command in the response stage at a time; the store access of the
  // next command never overlaps the data still being consumed.
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_RESP) && (!out_valid_r || out_tready);
  assign push_val  = size_mask(in_push_data, eb_r);
  assign front_val = pend_pop_r ? mem_rdata : front_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_ELEMENT_BYTES) ? CFG_DATA_W'(eb_r) : '0;

  always_comb begin
    state_nxt       = state_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    cnt_nxt         = cnt_r;
    front_nxt       = front_r;
    back_nxt        = back_r;
    eb_nxt          = eb_r;
    pend_status_nxt = pend_status_r;
    pend_rd_nxt     = pend_rd_r;
    pend_pop_nxt    = pend_pop_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_read_nxt    = out_read_r;
    out_front_nxt   = out_front_r;
    out_back_nxt    = out_back_r;
    out_count_nxt   = out_count_r;
    out_empty_nxt   = out_empty_r;
    mem_req         = '0;

    if (cfg_wr && (cfg_paddr[2] == REG_ELEMENT_BYTES)) begin
      eb_nxt = cfg_pwdata[EB_W-1:0];
    end

    // Accept: update pointers and count, issue at most one store access
    if (in_fire) begin
      state_nxt       = ST_RESP;
      pend_status_nxt = STAT_OK;
      pend_rd_nxt     = 1'b0;
      pend_pop_nxt    = 1'b0;
      unique case (in_cmd)
        CMD_PUSH: begin
          if (in_elem_bytes != TAG_W'(eb_r)) begin
            pend_status_nxt = STAT_SIZE;
          end else if (cnt_r == CNT_W'(DEPTH)) begin
            pend_status_nxt = STAT_FULL;
          end else begin
            mem_req.we    = 1'b1;
            mem_req.waddr = tail_r;
            mem_req.wdata = push_val;
            tail_nxt      = ptr_add(tail_r, INDEX_W'(1));
            cnt_nxt       = cnt_r + 1'b1;
            back_nxt      = push_val;
            if (cnt_r == '0) begin
              front_nxt = push_val;
            end
          end
        end
        CMD_POP: begin
          if (cnt_r == '0) begin
            pend_status_nxt = STAT_EMPTY;
          end else if (cnt_r == CNT_W'(1)) begin
            // last element gone: rewind both pointers
            cnt_nxt  = '0;
            head_nxt = '0;
            tail_nxt = '0;
          end else begin
            cnt_nxt       = cnt_r - 1'b1;
            head_nxt      = ptr_add(head_r, INDEX_W'(1));
            mem_req.re    = 1'b1;
            mem_req.raddr = head_nxt;
            pend_pop_nxt  = 1'b1;
          end
        end
        CMD_READ: begin
          if (cnt_r == '0) begin
            pend_status_nxt = STAT_EMPTY;
          end else if (in_elem_bytes < TAG_W'(eb_r)) begin
            pend_status_nxt = STAT_SIZE;
          end else if (CMP_W'(in_index) >= CMP_W'(cnt_r)) begin
            pend_status_nxt = STAT_RANGE;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = ptr_add(head_r, in_index);
            pend_rd_nxt   = 1'b1;
          end
        end
        CMD_CLEAR: begin
          cnt_nxt  = '0;
          head_nxt = '0;
          tail_nxt = '0;
        end
        default: begin
          pend_status_nxt = STAT_OK;
        end
      endcase
    end

    // Drain the output register when taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    // Response: fold in the store data and load the output register
    if (out_load) begin
      state_nxt      = ST_IDLE;
      front_nxt      = front_val;
      out_valid_nxt  = 1'b1;
      out_status_nxt = pend_status_r;
      out_read_nxt   = pend_rd_r ? mem_rdata : '0;
      out_front_nxt  = (cnt_r != '0) ? front_val : '0;
      out_back_nxt   = (cnt_r != '0) ? back_r : '0;
      out_count_nxt  = COUNT_W'(cnt_r);
      out_empty_nxt  = (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      eb_r        <= EB_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      eb_r        <= eb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r       <= front_nxt;
    back_r        <= back_nxt;
    pend_status_r <= pend_status_nxt;
    pend_rd_r     <= pend_rd_nxt;
    pend_pop_r    <= pend_pop_nxt;
    out_status_r  <= out_status_nxt;
    out_read_r    <= out_read_nxt;
    out_front_r   <= out_front_nxt;
    out_back_r    <= out_back_nxt;
    out_count_r   <= out_count_nxt;
    out_empty_r   <= out_empty_nxt;
  end

  fqir_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_empty_r, out_count_r, out_back_r, out_front_r, out_read_r};

endmodule

@@ hw/rtl/fqir_checker.sv @@
`include "fifo_queue_indexed_read_defines.svh"

module fqir_checker
  import fqir_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic [IN_TUSER_W-1:0]  in_tuser,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic                   cfg_psel,
  input logic                   cfg_penable,
  input logic                   cfg_pwrite,
  input logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input logic [CFG_DATA_W-1:0]  cfg_pwdata,
  input logic [CFG_DATA_W-1:0]  cfg_prdata,
  input logic                   cfg_pready
);

  // Hold a stalled result word.
  `FQIR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")

  // Empty flag follows the count.
  `FQIR_ASSERT_NOW(a_empty_count, out_tvalid, out_tdata[197] == (out_tdata[196:192] == '0), "empty flag disagrees with count")

  // An empty queue shows no front or back element.
  `FQIR_ASSERT_NOW(a_empty_zero, out_tvalid && out_tdata[197], (out_tdata[127:64] == '0) && (out_tdata[191:128] == '0), "front or back nonzero on empty queue")

  // Read data only comes with a successful command.
  `FQIR_ASSERT_NOW(a_read_ok, out_tvalid && (out_tdata[63:0] != '0), out_tuser == STAT_OK, "read data on failed command")

endmodule

bind fifo_queue_indexed_read fqir_checker u_fqir_checker (.*);
